/* hw/rtl/ir_pulse_distance_frame_decoder_defines.svh */
// ----------------------------------------------------------------------------
// ir pulse distance frame decoder assertion macros
// concurrent assertion shorthands clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_FRAME_DECODER_DEFINES_SVH

// same-cycle implication
`define IPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ipd_pkg.sv */
// ----------------------------------------------------------------------------
// ipd_pkg
// shared widths, register indexes and types of the ir frame decoder
// ----------------------------------------------------------------------------
package ipd_pkg;

    // field widths
    localparam int TICK_W     = 20;
    localparam int CODE_W     = 32;
    localparam int CODE_BITS  = 32;
    localparam int CNT_W      = 7;
    localparam int CFG_ADDR_W = 3;
    localparam int S_DATA_W   = 24;

    // frame layout, in intervals
    localparam logic [CNT_W-1:0] LAST_START = CNT_W'(1);
    localparam logic [CNT_W-1:0] LAST_MARK  = CNT_W'(66);
    localparam logic [CNT_W-1:0] LAST_INTV  = CNT_W'(67);

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_START_LOW  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_HIGH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_LOW   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ZERO_HIGH  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ONE_LOW    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_ONE_HIGH   = 3'd5;

    // register reset values
    localparam logic [TICK_W-1:0] START_LOW_RST  = TICK_W'(16000);
    localparam logic [TICK_W-1:0] START_HIGH_RST = TICK_W'(20000);
    localparam logic [TICK_W-1:0] ZERO_LOW_RST   = TICK_W'(1600);
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = TICK_W'(2900);
    localparam logic [TICK_W-1:0] ONE_LOW_RST    = TICK_W'(5800);
    localparam logic [TICK_W-1:0] ONE_HIGH_RST   = TICK_W'(7700);

    typedef struct packed {
        logic [TICK_W-1:0] start_low;
        logic [TICK_W-1:0] start_high;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] zero_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] one_high;
    } cfg_t;

    // window hits of one interval
    typedef struct packed {
        logic start_ok;
        logic mark_ok;
        logic bit_zero;
        logic bit_one;
    } check_t;

endpackage

/* hw/rtl/ipd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ipd_cfg_regs
// window threshold registers behind the plain write port
// ----------------------------------------------------------------------------
module ipd_cfg_regs
    import ipd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [TICK_W-1:0]     cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // address decode, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_START_LOW:  cfg_next.start_low  = cfg_wdata;
                CFG_START_HIGH: cfg_next.start_high = cfg_wdata;
                CFG_ZERO_LOW:   cfg_next.zero_low   = cfg_wdata;
                CFG_ZERO_HIGH:  cfg_next.zero_high  = cfg_wdata;
                CFG_ONE_LOW:    cfg_next.one_low    = cfg_wdata;
                CFG_ONE_HIGH:   cfg_next.one_high   = cfg_wdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low  <= START_LOW_RST;
            cfg_reg.start_high <= START_HIGH_RST;
            cfg_reg.zero_low   <= ZERO_LOW_RST;
            cfg_reg.zero_high  <= ZERO_HIGH_RST;
            cfg_reg.one_low    <= ONE_LOW_RST;
            cfg_reg.one_high   <= ONE_HIGH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/ipd_interval_check.sv */
// ----------------------------------------------------------------------------
// ipd_interval_check
// compares one interval against the start, mark and bit windows
// ----------------------------------------------------------------------------
module ipd_interval_check
    import ipd_pkg::*;
(
    input  logic [TICK_W-1:0] ticks,
    input  cfg_t              cfg,
    output check_t            chk
);

    // inclusive windows for start and mark intervals
    assign chk.start_ok = (ticks >= cfg.start_low) && (ticks <= cfg.start_high);
    assign chk.mark_ok  = (ticks >= cfg.zero_low)  && (ticks <= cfg.zero_high);

    // exclusive windows for data bits
    assign chk.bit_zero = (ticks > cfg.zero_low) && (ticks < cfg.zero_high);
    assign chk.bit_one  = (ticks > cfg.one_low)  && (ticks < cfg.one_high);

endmodule

/* hw/rtl/ipd_frame_track.sv */
// ----------------------------------------------------------------------------
// ipd_frame_track
// frame position, sticky error, bit shifter and result register
// ----------------------------------------------------------------------------
module ipd_frame_track
    import ipd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  check_t            chk,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [CODE_W-1:0] code,
    output logic              frame_ok
);

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CODE_BITS-1:0] shift_reg, shift_next;
    logic                 err_reg, err_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic                 ok_reg, ok_next;

    logic [CNT_W-1:0]     k;
    logic                 bad;
    logic                 bit_val;
    logic [CODE_BITS-1:0] shifted;
    logic                 emit;

    assign k       = CNT_W'(count_reg - CNT_W'(1));
    assign bit_val = !chk.bit_zero && chk.bit_one;
    assign shifted = CODE_BITS'({shift_reg, bit_val});
    assign emit    = advance && (count_reg != '0) && (k >= LAST_INTV);

    // which window this interval must hit
    always_comb
    begin
        bad = 1'b0;
        if (k <= LAST_START)
        begin
            bad = !chk.start_ok;
        end
        else if (k <= LAST_MARK)
        begin
            if (!k[0])
                bad = !chk.mark_ok;
            else
                bad = !chk.bit_zero && !chk.bit_one;
        end
    end

    // frame state update per accepted interval
    always_comb
    begin
        count_next = count_reg;
        shift_next = shift_reg;
        err_next   = err_reg;
        if (advance)
        begin
            if (count_reg == '0)
            begin
                count_next = CNT_W'(1);
                shift_next = '0;
                err_next   = 1'b0;
            end
            else if (emit)
            begin
                count_next = '0;
                shift_next = '0;
                err_next   = 1'b0;
            end
            else
            begin
                count_next = CNT_W'(count_reg + CNT_W'(1));
                if (!err_reg)
                begin
                    err_next = bad;
                    if (!bad && (k > LAST_START) && (k <= LAST_MARK) && k[0])
                        shift_next = shifted;
                end
            end
        end
    end

    // result register, loaded on the last interval of a frame
    always_comb
    begin
        code_next      = code_reg;
        ok_next        = ok_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (emit)
        begin
            out_valid_next = 1'b1;
            code_next      = err_reg ? '0 : CODE_W'(shift_reg);
            ok_next        = !err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            shift_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        ok_reg   <= ok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign code     = code_reg;
    assign frame_ok = ok_reg;

endmodule

/* hw/rtl/ir_pulse_distance_frame_decoder.sv */
// path: an edge transfer is registered in the input register and checked from there; the
// result of the 69th interval is then loaded into the result register for m_tdata/m_tuser
// throughput: one edge per cycle while the result register is free or being taken,
// set by the single check stage between the input and result registers
// reset: rst_n clears the frame position, error flag and valid bits and reloads the
// window registers with their default values; the block is ready right after reset
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// pulse distance ir frame decoder, one edge interval per transfer
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder
    import ipd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [TICK_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [19:0] elapsed_ticks, [23:20] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CODE_W-1:0]     m_tdata,   // [31:0] code
    output logic                  m_tuser    // [0] frame_ok
);

    cfg_t              cfg;
    check_t            chk;
    logic              in_valid_reg, in_valid_next;
    logic [TICK_W-1:0] ticks_reg;
    logic              advance;

    // interval leaves the input register when the result side can take it
    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            ticks_reg <= s_tdata[TICK_W-1:0];
    end

    ipd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ipd_interval_check u_interval_check (
        .ticks (ticks_reg),
        .cfg   (cfg),
        .chk   (chk)
    );

    ipd_frame_track u_frame_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .chk      (chk),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .code     (m_tdata),
        .frame_ok (m_tuser)
    );

endmodule

/* hw/rtl/ipd_checker.sv */
// ----------------------------------------------------------------------------
// ipd_checker
// port level checks of the ir frame decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "ir_pulse_distance_frame_decoder_defines.svh"

module ipd_checker
    import ipd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [CODE_W-1:0]     m_tdata,
    input logic                  m_tuser
);

    // stalled result holds
    `IPD_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // a failed frame reports a zero code
    `IPD_ASSERT_NOW(a_fail_zero, m_tvalid && !m_tuser, m_tdata == '0, "failed frame with nonzero code")

    // frames are many edges long, so results never come back to back
    `IPD_ASSERT_NEXT(a_result_gap, m_tvalid && m_tready, !m_tvalid, "results in adjacent cycles")

    // input side is ready whenever the result side can move
    `IPD_ASSERT_NOW(a_ready_flow, !m_tvalid || m_tready, s_tready, "input stalled without cause")

endmodule

bind ir_pulse_distance_frame_decoder ipd_checker u_ipd_checker (.*);
